[rtl/mfu_pkg.sv]
// Shared types and constants of the multiplicative function unit.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package mfu_pkg;

    localparam logic [1:0] CMD_PHI   = 2'd0;
    localparam logic [1:0] CMD_MU    = 2'd1;
    localparam logic [1:0] CMD_D     = 2'd2;
    localparam logic [1:0] CMD_SIGMA = 2'd3;

    localparam int VALUE_W     = 35;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;
    localparam int DIV_RADIX_BITS = 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 35'h3_FFFF_FFFF;

    typedef struct packed {
        logic load;
        logic div_start;
        logic take_quot;
        logic term_init;
        logic term_src_n;
        logic term_grow;
        logic mul_acc;
        logic next_prime;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic bad;
        logic n_gt1;
        logic psq_le_n;
        logic rem_zero;
        logic hit;
        logic div_busy;
        logic mul_busy;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

[rtl/mfu_ctrl.sv]
// Sequencer of the multiplicative function unit: trial division loop control.
// Depends on mfu_pkg; drives mfu_datapath through ctl_t, reads sts_t.
`default_nettype none

module mfu_ctrl
    import mfu_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  sts_t      sts,
    output ctl_t      ctl
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_TEST  = 4'd3;
    localparam logic [3:0] ST_GROW  = 4'd4;
    localparam logic [3:0] ST_ACCW  = 4'd5;
    localparam logic [3:0] ST_COFM  = 4'd6;
    localparam logic [3:0] ST_COFW  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.bad) begin
                    state_next = ST_DONE;
                end else if (sts.n_gt1 && sts.psq_le_n) begin
                    ctl.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else if (sts.n_gt1) begin
                    ctl.term_init  = 1'b1;
                    ctl.term_src_n = 1'b1;
                    state_next     = ST_COFM;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (sts.rem_zero) begin
                    ctl.take_quot = 1'b1;
                    if (sts.hit) begin
                        ctl.term_grow = 1'b1;
                    end else begin
                        ctl.term_init = 1'b1;
                    end
                    state_next = ST_GROW;
                end else if (sts.hit) begin
                    ctl.mul_acc = 1'b1;
                    state_next  = ST_ACCW;
                end else begin
                    ctl.next_prime = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_GROW: begin
                if (!sts.mul_busy) begin
                    ctl.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_ACCW: begin
                if (!sts.mul_busy) begin
                    ctl.next_prime = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_COFM: begin
                ctl.mul_acc = 1'b1;
                state_next  = ST_COFW;
            end
            ST_COFW: begin
                if (!sts.mul_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/mfu_datapath.sv]
// Datapath of the multiplicative function unit: radix-16 restoring divider,
// shift-add multiplier, accumulators and output register. Depends on mfu_pkg.
`default_nettype none

module mfu_datapath
    import mfu_pkg::*;
#(
    parameter int NUMBER_BITS = 31
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [S_TUSER_W-1:0]   s_cmd,
    input  wire logic [S_TDATA_W-1:0]   s_num,
    input  wire logic                   m_tready,
    input  ctl_t                        ctl,
    output sts_t                        sts,
    output logic                        m_valid,
    output logic [VALUE_W-1:0]          m_value,
    output logic                        m_bad
);

    localparam int NB        = NUMBER_BITS;
    localparam int ACC_W     = NB + 4;
    localparam int DIV_STEPS = (NB + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DW        = DIV_STEPS * DIV_RADIX_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic [1:0]       cmd_reg,     cmd_next;
    logic [NB-1:0]    n_reg,       n_next;
    logic             bad_reg,     bad_next;
    logic [NB-1:0]    p_reg,       p_next;
    logic [NB:0]      psq_reg,     psq_next;
    logic             hit_reg,     hit_next;
    logic             mu_neg_reg,  mu_neg_next;
    logic             mu_zero_reg, mu_zero_next;
    logic [ACC_W-1:0] t_reg,       t_next;
    logic [ACC_W-1:0] acc_reg,     acc_next;
    logic [DW-1:0]    dv_reg,      dv_next;
    logic [NB:0]      rem_reg,     rem_next;
    logic [CNT_W-1:0] dcnt_reg,    dcnt_next;
    logic             dbusy_reg,   dbusy_next;
    logic [ACC_W-1:0] ma_reg,      ma_next;
    logic [ACC_W-1:0] mb_reg,      mb_next;
    logic [ACC_W-1:0] mprod_reg,   mprod_next;
    logic             mbusy_reg,   mbusy_next;
    logic             mto_t_reg,   mto_t_next;
    logic             mplus_reg,   mplus_next;
    logic             ovalid_reg,  ovalid_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic             obad_reg,    obad_next;

    logic [NB:0]      r;
    logic [DW-1:0]    q;
    logic [NB-1:0]    x;
    logic [35:0]      acc_wide;

    assign acc_wide = 36'(acc_reg);

    always_comb begin
        cmd_next     = cmd_reg;
        n_next       = n_reg;
        bad_next     = bad_reg;
        p_next       = p_reg;
        psq_next     = psq_reg;
        hit_next     = hit_reg;
        mu_neg_next  = mu_neg_reg;
        mu_zero_next = mu_zero_reg;
        t_next       = t_reg;
        acc_next     = acc_reg;
        dv_next      = dv_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        dbusy_next   = dbusy_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        mprod_next   = mprod_reg;
        mbusy_next   = mbusy_reg;
        mto_t_next   = mto_t_reg;
        mplus_next   = mplus_reg;
        ovalid_next  = ovalid_reg;
        value_next   = value_reg;
        obad_next    = obad_reg;
        r            = rem_reg;
        q            = dv_reg;
        x            = ctl.term_src_n ? n_reg : p_reg;

        if (ctl.load) begin
            cmd_next     = s_cmd;
            n_next       = s_num[NB-1:0];
            bad_next     = (s_num[NB-1:0] == '0);
            p_next       = NB'(2);
            psq_next     = (NB+1)'(4);
            hit_next     = 1'b0;
            mu_neg_next  = 1'b0;
            mu_zero_next = 1'b0;
            acc_next     = ACC_W'(1);
        end

        if (ctl.take_quot) begin
            n_next = dv_reg[NB-1:0];
        end

        if (ctl.term_init) begin
            hit_next = 1'b1;
            case (cmd_reg)
                CMD_PHI:   t_next = ACC_W'(x) - ACC_W'(1);
                CMD_SIGMA: t_next = ACC_W'(x) + ACC_W'(1);
                CMD_D:     t_next = ACC_W'(2);
                CMD_MU:    mu_neg_next = !mu_neg_reg;
                default:   t_next = t_reg;
            endcase
        end

        if (ctl.term_grow) begin
            case (cmd_reg)
                CMD_PHI, CMD_SIGMA: begin
                    ma_next    = t_reg;
                    mb_next    = ACC_W'(p_reg);
                    mprod_next = '0;
                    mbusy_next = 1'b1;
                    mto_t_next = 1'b1;
                    mplus_next = (cmd_reg == CMD_SIGMA);
                end
                CMD_D:   t_next = t_reg + ACC_W'(1);
                CMD_MU:  mu_zero_next = 1'b1;
                default: t_next = t_reg;
            endcase
        end

        if (ctl.mul_acc && cmd_reg != CMD_MU) begin
            ma_next    = acc_reg;
            mb_next    = t_reg;
            mprod_next = '0;
            mbusy_next = 1'b1;
            mto_t_next = 1'b0;
            mplus_next = 1'b0;
        end

        if (ctl.next_prime) begin
            hit_next = 1'b0;
            if (p_reg == NB'(2)) begin
                p_next   = NB'(3);
                psq_next = (NB+1)'(9);
            end else begin
                p_next   = p_reg + NB'(2);
                psq_next = psq_reg + (NB+1)'({p_reg, 2'b00}) + (NB+1)'(4);
            end
        end

        // shift-add multiply, stop once the multiplier runs out of ones
        if (mbusy_reg) begin
            if (mb_reg != '0) begin
                if (mb_reg[0]) begin
                    mprod_next = mprod_reg + ma_reg;
                end
                ma_next = {ma_reg[ACC_W-2:0], 1'b0};
                mb_next = {1'b0, mb_reg[ACC_W-1:1]};
            end else begin
                mbusy_next = 1'b0;
                if (mto_t_reg) begin
                    t_next = mprod_reg + ACC_W'(mplus_reg);
                end else begin
                    acc_next = mprod_reg;
                end
            end
        end

        // restoring division, four quotient bits per cycle
        if (ctl.div_start) begin
            dv_next    = DW'(n_reg);
            rem_next   = '0;
            dcnt_next  = '0;
            dbusy_next = 1'b1;
        end else if (dbusy_reg) begin
            for (int k = 0; k < DIV_RADIX_BITS; k++) begin
                r = {r[NB-1:0], q[DW-1]};
                q = {q[DW-2:0], 1'b0};
                if (r >= {1'b0, p_reg}) begin
                    r    = r - {1'b0, p_reg};
                    q[0] = 1'b1;
                end
            end
            dv_next   = q;
            rem_next  = r;
            dcnt_next = dcnt_reg + CNT_W'(1);
            if (dcnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                dbusy_next = 1'b0;
            end
        end

        if (ctl.out_load) begin
            ovalid_next = 1'b1;
            obad_next   = bad_reg;
            if (bad_reg) begin
                value_next = '0;
            end else if (cmd_reg == CMD_MU) begin
                if (mu_zero_reg) begin
                    value_next = '0;
                end else if (mu_neg_reg) begin
                    value_next = '1;
                end else begin
                    value_next = VALUE_W'(1);
                end
            end else if (acc_wide > 36'(VALUE_MAX)) begin
                value_next = VALUE_MAX;
            end else begin
                value_next = acc_wide[VALUE_W-1:0];
            end
        end else if (m_tready) begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg  <= 1'b0;
            mbusy_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            dbusy_reg  <= dbusy_next;
            mbusy_reg  <= mbusy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        n_reg       <= n_next;
        bad_reg     <= bad_next;
        p_reg       <= p_next;
        psq_reg     <= psq_next;
        hit_reg     <= hit_next;
        mu_neg_reg  <= mu_neg_next;
        mu_zero_reg <= mu_zero_next;
        t_reg       <= t_next;
        acc_reg     <= acc_next;
        dv_reg      <= dv_next;
        rem_reg     <= rem_next;
        dcnt_reg    <= dcnt_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        mprod_reg   <= mprod_next;
        mto_t_reg   <= mto_t_next;
        mplus_reg   <= mplus_next;
        value_reg   <= value_next;
        obad_reg    <= obad_next;
    end

    assign sts.bad      = bad_reg;
    assign sts.n_gt1    = (n_reg > NB'(1));
    assign sts.psq_le_n = (psq_reg <= {1'b0, n_reg});
    assign sts.rem_zero = (rem_reg == '0);
    assign sts.hit      = hit_reg;
    assign sts.div_busy = dbusy_reg;
    assign sts.mul_busy = mbusy_reg;
    assign sts.out_free = !ovalid_reg || m_tready;

    assign m_valid = ovalid_reg;
    assign m_value = value_reg;
    assign m_bad   = obad_reg;

endmodule

`default_nettype wire

[rtl/multiplicative_function_unit.sv]
// Top level of the multiplicative function unit (phi, mu, d, sigma).
// Depends on mfu_pkg, mfu_ctrl and mfu_datapath.
//
//  channel | dir | ports                        | content
//  --------+-----+------------------------------+--------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata/user | number, command
//  m_      | out | m_tvalid m_tready m_tdata/user | value, bad_argument
//
// One item at a time. Each odd trial divisor takes check, a radix-16 divider
// pass, the done wait and test, plus a shift-add multiply per prime power found
// (per prime for d, none for mu). Reset is synchronous, active low, and clears
// the sequencer, the busy flags and the output valid flag. A new beat is taken
// while a finished result still waits in the output register.
`default_nettype none

module multiplicative_function_unit
    import mfu_pkg::*;
#(
    parameter int NUMBER_BITS = 31
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // number
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // command
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // value
    output logic                      m_tuser    // bad_argument
);

    ctl_t               ctl;
    sts_t               sts;
    logic [VALUE_W-1:0] value;

    mfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    mfu_datapath #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_cmd    (s_tuser),
        .s_num    (s_tdata),
        .m_tready (m_tready),
        .ctl      (ctl),
        .sts      (sts),
        .m_valid  (m_tvalid),
        .m_value  (value),
        .m_bad    (m_tuser)
    );

    assign m_tdata = {{(M_TDATA_W - VALUE_W){1'b0}}, value};

endmodule

`default_nettype wire

[rtl/mfu_checker.sv]
// Port-level checks for the multiplicative function unit, bound to the top level.
// Depends on mfu_pkg.
`default_nettype none

module mfu_checker
    import mfu_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("bad argument with nonzero value");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:VALUE_W] == '0)
        else $error("pad bits of result set");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

endmodule

bind multiplicative_function_unit mfu_checker u_mfu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
